// ===== rtl/chained_two_bit_map_transcoder_defines.svh =====
// ----------------------------------------------------------------------------
// Chained two-bit map transcoder assertion macros
// Shared concurrent assertion forms used by the transcoder modules.
// ----------------------------------------------------------------------------
`ifndef CHAINED_TWO_BIT_MAP_TRANSCODER_DEFINES_SVH
`define CHAINED_TWO_BIT_MAP_TRANSCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Transcoder package
// Types, register indexes and code table helpers shared by the transcoder.
// ----------------------------------------------------------------------------
package cbt_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [7:0]  BASE_CODES_RST = 8'd27;
    localparam logic [15:0] CHUNK_LEN_RST  = 16'd64;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DECODE_MODE = 2'd0,
        REG_BASE_CODES  = 2'd1,
        REG_CHUNK_LEN   = 2'd2
    } t_reg_idx;

    // One classified item as it travels from the front end to the back end.
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] map;
        logic       taken;
        logic       head;
    } t_item;

    // Configuration seen by the back end.
    typedef struct packed {
        logic       decode_mode;
        logic [7:0] base_codes;
    } t_cfg;

    // Two-bit field of a byte; field 0 is the top pair.
    function automatic logic [1:0] field2(input logic [7:0] b, input logic [1:0] idx);
        logic [1:0] f;
        case (idx)
            2'd0:    f = b[7:6];
            2'd1:    f = b[5:4];
            2'd2:    f = b[3:2];
            default: f = b[1:0];
        endcase
        return f;
    endfunction

    // Code table entry M[p][c].
    function automatic logic [1:0] code_at(input logic [7:0] base, input logic [7:0] map,
                                           input logic [1:0] p, input logic [1:0] c);
        return field2(base, c) ^ field2(map, p);
    endfunction

endpackage

// ===== rtl/cbt_front.sv =====
// ----------------------------------------------------------------------------
// Transcoder front end
// Accepts items, tracks chunk boundaries and the current map, marks heads.
// ----------------------------------------------------------------------------
`include "chained_two_bit_map_transcoder_defines.svh"

module cbt_front #(
    parameter int unsigned CHUNK_COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [15:0]          i_chunk_len,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_in,
    input  logic                 i_change_bit,
    input  logic [7:0]           i_map_byte,
    input  logic                 i_stream_start,
    output logic                 o_push,
    input  logic                 i_q_ready,
    output cbt_pkg::t_item       o_item
);
    import cbt_pkg::*;

    localparam int unsigned W = CHUNK_COUNT_WIDTH;

    logic [W-1:0]  r_chunk_rem, n_chunk_rem;
    logic [7:0]    r_cur_map, n_cur_map;
    logic          r_head_pending, n_head_pending;

    logic          accept;
    logic [W-1:0]  rem_eff;
    logic          chunk_start;
    logic          load_map;
    logic [W+15:0] len_ext;
    logic [W-1:0]  len;
    logic [W-1:0]  len_m1;

    assign o_ready = i_q_ready;
    assign o_push  = i_valid;
    assign accept  = i_valid && i_q_ready;

    always_comb begin
        rem_eff     = i_stream_start ? '0 : r_chunk_rem;
        chunk_start = (rem_eff == '0);
        load_map    = chunk_start && !i_change_bit;
        len_ext     = {{W{1'b0}}, i_chunk_len};
        len         = len_ext[W-1:0];
        // A zero length behaves as one: the map is checked at every item.
        len_m1      = (len == '0) ? '0 : len - W'(1);

        o_item.data  = i_data_in;
        o_item.map   = load_map ? i_map_byte : r_cur_map;
        o_item.taken = load_map;
        o_item.head  = i_stream_start || r_head_pending;

        n_chunk_rem    = r_chunk_rem;
        n_cur_map      = r_cur_map;
        n_head_pending = r_head_pending;
        if (accept) begin
            n_chunk_rem    = chunk_start ? len_m1 : rem_eff - W'(1);
            n_cur_map      = o_item.map;
            n_head_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_rem    <= '0;
            r_cur_map      <= '0;
            r_head_pending <= 1'b1;
        end else begin
            r_chunk_rem    <= n_chunk_rem;
            r_cur_map      <= n_cur_map;
            r_head_pending <= n_head_pending;
        end
    end

    `CBT_ASSERT_NEXT(a_map_load, i_clk, i_rst_n,
        accept && (i_stream_start || r_chunk_rem == '0) && !i_change_bit,
        r_cur_map == $past(i_map_byte), "map byte not loaded at chunk start")
    `CBT_ASSERT_NEXT(a_map_hold, i_clk, i_rst_n,
        accept && !i_stream_start && r_chunk_rem != '0,
        r_cur_map == $past(r_cur_map), "map changed inside a chunk")

endmodule

// ===== rtl/cbt_queue.sv =====
// ----------------------------------------------------------------------------
// Transcoder item queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`include "chained_two_bit_map_transcoder_defines.svh"

module cbt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_ready,
    input  cbt_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_pop,
    output cbt_pkg::t_item o_item
);
    import cbt_pkg::*;

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           push;
    logic           pop;

    assign o_ready = (r_count != CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        case ({push, pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `CBT_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1,
        r_count <= CW'(QUEUE_DEPTH), "queue count beyond depth")
    `CBT_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, push && !pop,
        r_count == $past(r_count) + CW'(1), "queue count missed a push")

endmodule

// ===== rtl/cbt_back.sv =====
// ----------------------------------------------------------------------------
// Transcoder back end
// Runs the symbol chain for encode or decode and holds the output register.
// ----------------------------------------------------------------------------
module cbt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cbt_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  cbt_pkg::t_item i_q_item,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_data,
    output logic           o_taken
);
    import cbt_pkg::*;

    logic       r_out_valid, n_out_valid;
    logic [1:0] r_prev_tail;
    logic [7:0] r_data;
    logic       r_taken;

    logic       pop;
    logic [1:0] s0, s1, s2, s3;
    logic [1:0] r0, r1, r2, r3;
    logic [7:0] res;
    logic [1:0] tail;

    assign pop     = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop = pop;

    always_comb begin
        s0 = field2(i_q_item.data, 2'd0);
        s1 = field2(i_q_item.data, 2'd1);
        s2 = field2(i_q_item.data, 2'd2);
        s3 = field2(i_q_item.data, 2'd3);
        r0 = i_q_item.head ? s0
                           : code_at(i_cfg.base_codes, i_q_item.map, r_prev_tail, s0);
        // Decoding feeds each restored symbol into the next lookup.
        r1 = code_at(i_cfg.base_codes, i_q_item.map, r0, s1);
        r2 = code_at(i_cfg.base_codes, i_q_item.map, r1, s2);
        r3 = code_at(i_cfg.base_codes, i_q_item.map, r2, s3);
        if (i_cfg.decode_mode) begin
            res  = {r0, r1, r2, r3};
            tail = r3;
        end else begin
            res  = {r0,
                    code_at(i_cfg.base_codes, i_q_item.map, s0, s1),
                    code_at(i_cfg.base_codes, i_q_item.map, s1, s2),
                    code_at(i_cfg.base_codes, i_q_item.map, s2, s3)};
            tail = s3;
        end

        if (pop) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev_tail <= 2'd0;
        end else begin
            r_out_valid <= n_out_valid;
            if (pop) begin
                r_prev_tail <= tail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_data  <= res;
            r_taken <= i_q_item.taken;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_data;
    assign o_taken = r_taken;

endmodule

// ===== rtl/chained_two_bit_map_transcoder.sv =====
// ----------------------------------------------------------------------------
// Chained two-bit map transcoder
// Converts a byte stream symbol pair by symbol pair through a mapped table.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on i_in_valid / o_in_ready with a data byte, a change
// bit, a candidate map byte and a stream start flag. Each item produces
// exactly one result item on o_out_valid / i_out_ready carrying the
// converted byte and a flag telling whether the map byte was loaded.
// An accepted item is registered in the queue and then in the output
// register before o_out_valid. Throughput is one item per cycle while the
// output is not stalled: the front end classifies an item in its accept
// cycle; the back end resolves the whole four-symbol chain combinationally.
// A two-entry queue sits between front and back. When the receiver stalls,
// the output register holds, the queue fills, and o_in_ready drops only
// once both queue entries are occupied.
// Reset (synchronous, active low) empties the queue and output, restores
// the registers to decode_mode 0, base_codes 27, chunk_len 64, clears the
// map and marks the next item as a head item that opens a chunk.
// Configuration writes through i_cfg_we / i_cfg_addr / i_cfg_data take
// effect at once and are meant to happen while the block is idle.
// ----------------------------------------------------------------------------
module chained_two_bit_map_transcoder #(
    parameter int unsigned CHUNK_COUNT_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cbt_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [cbt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_data_in,
    input  logic                               i_change_bit,
    input  logic [7:0]                         i_map_byte,
    input  logic                               i_stream_start,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [7:0]                         o_data_out,
    output logic                               o_map_taken
);
    import cbt_pkg::*;

    // Configuration registers.
    logic        r_decode_mode;
    logic [7:0]  r_base_codes;
    logic [15:0] r_chunk_len;

    // Front end to queue, queue to back end.
    logic  front_push;
    logic  q_ready;
    t_item front_item;
    logic  q_valid;
    logic  q_pop;
    t_item q_item;
    t_cfg  back_cfg;

    // The index decoder ignores writes to indexes past the register list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= 1'b0;
            r_base_codes  <= BASE_CODES_RST;
            r_chunk_len   <= CHUNK_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_DECODE_MODE: r_decode_mode <= i_cfg_data[0];
                REG_BASE_CODES:  r_base_codes  <= i_cfg_data[7:0];
                REG_CHUNK_LEN:   r_chunk_len   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign back_cfg.decode_mode = r_decode_mode;
    assign back_cfg.base_codes  = r_base_codes;

    // The front end owns the chunk counter, the current map and head tracking.
    cbt_front #(
        .CHUNK_COUNT_WIDTH (CHUNK_COUNT_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_chunk_len    (r_chunk_len),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_data_in      (i_data_in),
        .i_change_bit   (i_change_bit),
        .i_map_byte     (i_map_byte),
        .i_stream_start (i_stream_start),
        .o_push         (front_push),
        .i_q_ready      (q_ready),
        .o_item         (front_item)
    );

    cbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .o_ready (q_ready),
        .i_item  (front_item),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    // The back end owns the chain tail that links consecutive items.
    cbt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (back_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_data_out),
        .o_taken   (o_map_taken)
    );

endmodule
